@@ rtl/dwr_pkg.sv @@
// Shared types, constants and classification for the drawing record walker.
package dwr_pkg;

  localparam int STACK_DEPTH = 10;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_W        = 64;
  localparam int OUT_W       = 152;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic REG_STREAM_LEN = 1'b0;

  localparam logic [3:0] REC_HDR_BYTES = 4'd8;

  // status codes
  localparam logic [1:0] STS_ACCEPT  = 2'd0;
  localparam logic [1:0] STS_END     = 2'd1;
  localparam logic [1:0] STS_OVERRUN = 2'd2;
  localparam logic [1:0] STS_HALT    = 2'd3;

  // image formats
  localparam logic [3:0] FMT_NONE  = 4'd0;
  localparam logic [3:0] FMT_EMF   = 4'd1;
  localparam logic [3:0] FMT_WMF   = 4'd2;
  localparam logic [3:0] FMT_PICT  = 4'd3;
  localparam logic [3:0] FMT_JPEG  = 4'd4;
  localparam logic [3:0] FMT_PNG   = 4'd5;
  localparam logic [3:0] FMT_DIB   = 4'd6;
  localparam logic [3:0] FMT_TIFF  = 4'd7;
  localparam logic [3:0] FMT_UNSUP = 4'd8;

  localparam logic [15:0] TYPE_PREFIX_MASK = 16'hF000;
  localparam logic [15:0] TYPE_IMG_LO      = 16'hF018;
  localparam logic [15:0] TYPE_IMG_HI      = 16'hF117;
  localparam logic [15:0] TYPE_EMF         = 16'hF01A;
  localparam logic [15:0] TYPE_WMF         = 16'hF01B;
  localparam logic [15:0] TYPE_PICT        = 16'hF01C;
  localparam logic [15:0] TYPE_JPEG        = 16'hF01D;
  localparam logic [15:0] TYPE_PNG         = 16'hF01E;
  localparam logic [15:0] TYPE_DIB         = 16'hF01F;
  localparam logic [15:0] TYPE_TIFF        = 16'hF029;

  localparam logic [11:0] INST_EMF   = 12'h3D4;
  localparam logic [11:0] INST_WMF   = 12'h216;
  localparam logic [11:0] INST_PICT  = 12'h542;
  localparam logic [11:0] INST_JPEG  = 12'h46A;
  localparam logic [11:0] INST_JPEG2 = 12'h6E2;
  localparam logic [11:0] INST_PNG   = 12'h6E0;
  localparam logic [11:0] INST_DIB   = 12'h7A8;
  localparam logic [11:0] INST_TIFF  = 12'h6E4;

  localparam logic [6:0] PFX_NONE  = 7'd0;
  localparam logic [6:0] PFX_RAS1  = 7'd17;
  localparam logic [6:0] PFX_RAS2  = 7'd33;
  localparam logic [6:0] PFX_META1 = 7'd50;
  localparam logic [6:0] PFX_META2 = 7'd66;

  // classified request between front and back
  typedef struct packed {
    logic        cont;
    logic        marker;
    logic [3:0]  fmt;
    logic [6:0]  prefix;
    logic        meta;
    logic [31:0] plen;
    logic [31:0] len;
  } dwr_item_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] cpos;
    logic        meta;
    logic [31:0] plen;
    logic [31:0] ppos;
    logic [6:0]  prefix;
    logic [3:0]  fmt;
    logic        cont;
    logic [3:0]  depth;
    logic [31:0] rpos;
    logic [1:0]  status;
  } dwr_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dwr_qstat_t;

  function automatic logic [6:0] pick_pfx(input logic [11:0] inst, input logic [11:0] base,
                                          input logic [6:0] p0, input logic [6:0] p1);
    logic [6:0] p;
    p = PFX_NONE;
    if (inst == base) p = p0;
    else if (inst == base + 12'd1) p = p1;
    return p;
  endfunction

endpackage

@@ rtl/dwr_queue.sv @@
// Short request queue between the classifying front and the walking back end.
module dwr_queue import dwr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dwr_item_t  push_item,
  input  logic       pop,
  output dwr_item_t  head_item,
  output dwr_qstat_t qstat
);

  dwr_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign head_item   = mem_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);

endmodule

@@ rtl/dwr_front.sv @@
// Input side: takes record headers and classifies type, image format and prefix.
module dwr_front import dwr_pkg::*; (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  dwr_qstat_t      qstat,
  output logic            push,
  output dwr_item_t       push_item
);

  logic [3:0]  version;
  logic [11:0] inst;
  logic [15:0] rtype;
  logic [31:0] len;
  logic [3:0]  fmt;
  logic [6:0]  pfx;
  logic        meta_fmt;

  assign version = in_tdata[3:0];
  assign inst    = in_tdata[15:4];
  assign rtype   = in_tdata[31:16];
  assign len     = in_tdata[63:32];

  always_comb begin
    fmt      = FMT_UNSUP;
    pfx      = PFX_NONE;
    meta_fmt = 1'b0;
    case (rtype)
      TYPE_EMF: begin
        fmt = FMT_EMF;  meta_fmt = 1'b1; pfx = pick_pfx(inst, INST_EMF, PFX_META1, PFX_META2);
      end
      TYPE_WMF: begin
        fmt = FMT_WMF;  meta_fmt = 1'b1; pfx = pick_pfx(inst, INST_WMF, PFX_META1, PFX_META2);
      end
      TYPE_PICT: begin
        fmt = FMT_PICT; meta_fmt = 1'b1; pfx = pick_pfx(inst, INST_PICT, PFX_META1, PFX_META2);
      end
      TYPE_JPEG: begin
        fmt = FMT_JPEG;
        pfx = pick_pfx(inst, INST_JPEG, PFX_RAS1, PFX_RAS2);
        if (pfx == PFX_NONE) pfx = pick_pfx(inst, INST_JPEG2, PFX_RAS1, PFX_RAS2);
      end
      TYPE_PNG: begin
        fmt = FMT_PNG;  pfx = pick_pfx(inst, INST_PNG, PFX_RAS1, PFX_RAS2);
      end
      TYPE_DIB: begin
        fmt = FMT_DIB;  pfx = pick_pfx(inst, INST_DIB, PFX_RAS1, PFX_RAS2);
      end
      TYPE_TIFF: begin
        fmt = FMT_TIFF; pfx = pick_pfx(inst, INST_TIFF, PFX_RAS1, PFX_RAS2);
      end
      default: begin
        fmt = FMT_UNSUP;
      end
    endcase
  end

  always_comb begin
    push_item.cont   = (version == 4'hF);
    push_item.marker = ((rtype & TYPE_PREFIX_MASK) != TYPE_PREFIX_MASK);
    push_item.len    = len;
    push_item.fmt    = FMT_NONE;
    push_item.prefix = PFX_NONE;
    push_item.meta   = 1'b0;
    push_item.plen   = '0;
    if (rtype >= TYPE_IMG_LO && rtype <= TYPE_IMG_HI) begin
      if (pfx == PFX_NONE) begin
        push_item.fmt = FMT_UNSUP;
      end else begin
        push_item.fmt    = fmt;
        push_item.prefix = pfx;
        push_item.meta   = meta_fmt;
        push_item.plen   = (len > 32'(pfx)) ? len - 32'(pfx) : '0;
      end
    end
  end

  assign in_tready = !qstat.full;
  assign push      = in_tvalid && in_tready;

endmodule

@@ rtl/dwr_back.sv @@
// Back end: pops ended containers, checks bounds, advances position, builds results.
module dwr_back import dwr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      stream_len,
  input  dwr_item_t        head_item,
  input  dwr_qstat_t       qstat,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  typedef enum logic [1:0] {
    ST_POP  = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t          state_r, state_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic            halted_r, halted_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]     stack_r [STACK_DEPTH];
  logic            out_valid_r, out_valid_nxt;
  dwr_result_t     res_r, res_nxt;

  logic            top_ended;
  logic            exhausted;
  logic [32:0]     end_pos;
  logic            overrun;
  logic            fire;
  logic            push_en;
  logic [IDX_W-1:0] top_idx;

  assign top_idx   = IDX_W'(cnt_r - 1'b1);
  assign top_ended = (cnt_r != '0) && (pos_r >= stack_r[top_idx]);
  assign exhausted = (stream_len < 32'(REC_HDR_BYTES)) ||
                     (pos_r >= stream_len - 32'(REC_HDR_BYTES));
  assign end_pos   = {1'b0, pos_r} + 33'(REC_HDR_BYTES) + {1'b0, head_item.len};
  assign overrun   = end_pos > {1'b0, stream_len};
  assign fire      = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign pop       = fire;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    halted_nxt    = halted_r;
    cnt_nxt       = cnt_r;
    push_en       = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;
    case (state_r)
      ST_POP: begin
        if (!qstat.empty) begin
          if (!halted_r && top_ended) cnt_nxt = cnt_r - 1'b1;
          else state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt     = ST_POP;
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          res_nxt.rpos  = pos_r;
          res_nxt.depth = 4'(cnt_r);
          if (halted_r) begin
            res_nxt.status = STS_HALT;
          end else if (exhausted) begin
            res_nxt.status = STS_HALT;
            halted_nxt     = 1'b1;
          end else begin
            res_nxt.cont = head_item.cont;
            if (head_item.marker) begin
              res_nxt.status = STS_END;
              halted_nxt     = 1'b1;
            end else if (overrun) begin
              res_nxt.status = STS_OVERRUN;
              halted_nxt     = 1'b1;
            end else begin
              res_nxt.status = STS_ACCEPT;
              if (head_item.cont) begin
                pos_nxt = pos_r + 32'(REC_HDR_BYTES);
                if (cnt_r < CNT_W'(STACK_DEPTH)) begin
                  push_en = 1'b1;
                  cnt_nxt = cnt_r + 1'b1;
                end
              end else begin
                pos_nxt = end_pos[31:0];
              end
              res_nxt.fmt    = head_item.fmt;
              res_nxt.prefix = head_item.prefix;
              res_nxt.plen   = head_item.plen;
              res_nxt.meta   = head_item.meta;
              if (head_item.prefix != PFX_NONE) begin
                res_nxt.ppos = pos_r + 32'(REC_HDR_BYTES) + 32'(head_item.prefix);
              end
              if (head_item.meta) begin
                res_nxt.cpos = pos_r + 32'(REC_HDR_BYTES) + 32'(head_item.prefix) - 32'd2;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_POP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_POP;
      pos_r       <= '0;
      halted_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      halted_r    <= halted_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (push_en) stack_r[IDX_W'(cnt_r)] <= end_pos[31:0];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

endmodule

@@ rtl/drawing_record_walker_top.sv @@
// Top level of the drawing record walker: config register, front, queue and back end.
//
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid/in_tready    record header, 64 bits
// out_      master     out_tvalid/out_tready  result, 152 bits
// cfg_      APB        psel/penable/pready    stream_length at address 0
//
// Each request goes through the back end's ST_POP, popping ended containers, then ST_EXEC.
// The pop loop over the container stack sets the rate; the front classifies in the
// cycle of acceptance and a two-entry queue lets the input keep flowing.
// rst_n is synchronous, active low; it clears position, halted flag, stack count and
// stream_length. Output stalls hold the result register; the queue absorbs input.
module drawing_record_walker_top import dwr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // version[3:0], instance_req[15:4],
                                            // record_type[31:16], record_length[63:32]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // status[1:0], header_pos[33:2], depth[37:34],
                                            // container_flag[38], blip_format[42:39],
                                            // prefix_bytes[49:43], payload_pos[81:50],
                                            // payload_len[113:82], metafile_header[114],
                                            // compression_byte_pos[146:115], zero[151:147]
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [31:0] stream_len_r;
  logic        cfg_hit;
  logic        push;
  logic        pop;
  dwr_item_t   push_item;
  dwr_item_t   head_item;
  dwr_qstat_t  qstat;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == REG_STREAM_LEN);
  assign cfg_prdata = cfg_hit ? stream_len_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_len_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      stream_len_r <= cfg_pwdata;
    end
  end

  dwr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  dwr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  dwr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stream_len (stream_len_r),
    .head_item  (head_item),
    .qstat      (qstat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ rtl/dwr_checker.sv @@
// Port-level checks on the drawing record walker results, bound to the top level.
module dwr_checker import dwr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_rejected_no_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != STS_ACCEPT |->
      out_tdata[OUT_W-1:39] == '0)
    else $error("image fields set on a rejected request");

  a_halt_no_container: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == STS_HALT |-> !out_tdata[38])
    else $error("container flag on a halted request");

  a_meta_cpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[114] |->
      out_tdata[146:115] == out_tdata[81:50] - 32'd2 && out_tdata[49:43] != PFX_NONE)
    else $error("compression byte position inconsistent");

endmodule

bind drawing_record_walker_top dwr_checker u_dwr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/tb_drawing_record_walker_top.sv @@
// Testbench for drawing_record_walker_top: header stream against a self-checking walk predictor.
`timescale 1ns / 100ps

module tb_drawing_record_walker_top import dwr_pkg::*; ();

  localparam logic [3:0] CONTAINER_VER = 4'hF;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int CHUNK_ITEMS = 480;
  localparam logic [CFG_ADDR_W-1:0] ADDR_STREAM_LEN = {REG_STREAM_LEN, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = 3'd4;
  localparam logic [15:0] IMG_TYPES [7] = '{TYPE_EMF, TYPE_WMF, TYPE_PICT, TYPE_JPEG,
                                            TYPE_PNG, TYPE_DIB, TYPE_TIFF};
  localparam logic [11:0] IMG_INSTS [7] = '{INST_EMF, INST_WMF, INST_PICT, INST_JPEG,
                                            INST_PNG, INST_DIB, INST_TIFF};

  typedef struct packed {
    logic [31:0] len;
    logic [15:0] rtype;
    logic [11:0] inst;
    logic [3:0]  ver;
  } rec_hdr_t;

  typedef enum {
    STOP_SHORT_STREAM, STOP_EXACT_FIT, STOP_MARKER, STOP_OVERRUN_BY_ONE, STOP_OVERRUN_MAX
  } stop_kind_t;

  class record_walk_scoreboard;
    logic [31:0] stream_len;
    logic [31:0] position;
    bit          halted;
    logic [31:0] container_end [STACK_DEPTH];
    int unsigned open_count;
    dwr_result_t expected_results [$];
    int          errors;

    function new();
      stream_len = '0;
      position   = '0;
      halted     = 1'b0;
      open_count = 0;
      errors     = 0;
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] addr, logic [31:0] value);
      if (addr == ADDR_STREAM_LEN) stream_len = value;
    endfunction

    function logic [6:0] pair_prefix(logic [11:0] inst, logic [11:0] base,
                                     logic [6:0] first, logic [6:0] second);
      logic [11:0] d;
      d = inst - base;
      if (d == 12'd0) return first;
      if (d == 12'd1) return second;
      return PFX_NONE;
    endfunction

    function dwr_result_t predict_record(rec_hdr_t h);
      dwr_result_t r;
      logic [33:0] rec_end;
      logic [3:0]  fmt;
      logic [6:0]  pfx;
      logic        meta;
      r = '0;
      if (!halted)
        while (open_count > 0 && position >= container_end[open_count-1]) open_count--;
      r.rpos  = position;
      r.depth = open_count[3:0];
      if (halted) begin
        r.status = STS_HALT;
        return r;
      end
      if (stream_len < 32'd8 || position >= stream_len - 32'd8) begin
        halted   = 1'b1;
        r.status = STS_HALT;
        return r;
      end
      r.cont = (h.ver == CONTAINER_VER);
      if ((h.rtype & TYPE_PREFIX_MASK) != TYPE_PREFIX_MASK) begin
        halted   = 1'b1;
        r.status = STS_END;
        return r;
      end
      rec_end = {2'b00, position} + 34'd8 + {2'b00, h.len};
      if (rec_end > {2'b00, stream_len}) begin
        halted   = 1'b1;
        r.status = STS_OVERRUN;
        return r;
      end
      r.status = STS_ACCEPT;
      if (r.cont) begin
        position = position + 32'd8;
        if (open_count < STACK_DEPTH) begin
          container_end[open_count] = rec_end[31:0];
          open_count++;
        end
      end else begin
        position = rec_end[31:0];
      end
      if (h.rtype >= TYPE_IMG_LO && h.rtype <= TYPE_IMG_HI) begin
        fmt  = FMT_UNSUP;
        pfx  = PFX_NONE;
        meta = 1'b0;
        case (h.rtype)
          TYPE_EMF: begin
            fmt = FMT_EMF;  meta = 1'b1;
            pfx = pair_prefix(h.inst, INST_EMF, PFX_META1, PFX_META2);
          end
          TYPE_WMF: begin
            fmt = FMT_WMF;  meta = 1'b1;
            pfx = pair_prefix(h.inst, INST_WMF, PFX_META1, PFX_META2);
          end
          TYPE_PICT: begin
            fmt = FMT_PICT; meta = 1'b1;
            pfx = pair_prefix(h.inst, INST_PICT, PFX_META1, PFX_META2);
          end
          TYPE_JPEG: begin
            fmt = FMT_JPEG;
            pfx = pair_prefix(h.inst, INST_JPEG, PFX_RAS1, PFX_RAS2);
            if (pfx == PFX_NONE) pfx = pair_prefix(h.inst, INST_JPEG2, PFX_RAS1, PFX_RAS2);
          end
          TYPE_PNG: begin
            fmt = FMT_PNG;
            pfx = pair_prefix(h.inst, INST_PNG, PFX_RAS1, PFX_RAS2);
          end
          TYPE_DIB: begin
            fmt = FMT_DIB;
            pfx = pair_prefix(h.inst, INST_DIB, PFX_RAS1, PFX_RAS2);
          end
          TYPE_TIFF: begin
            fmt = FMT_TIFF;
            pfx = pair_prefix(h.inst, INST_TIFF, PFX_RAS1, PFX_RAS2);
          end
          default: ;
        endcase
        if (pfx == PFX_NONE) begin
          r.fmt = FMT_UNSUP;
        end else begin
          r.fmt    = fmt;
          r.prefix = pfx;
          r.ppos   = r.rpos + 32'd8 + 32'(pfx);
          r.plen   = (h.len > 32'(pfx)) ? h.len - 32'(pfx) : 32'd0;
          r.meta   = meta;
          r.cpos   = meta ? r.ppos - 32'd2 : 32'd0;
        end
      end
      return r;
    endfunction

    function void note_header(rec_hdr_t h);
      expected_results.push_back(predict_record(h));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(dwr_result_t got);
      dwr_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing outstanding: 0x%0h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("header_pos", want.rpos, got.rpos);
      check_field("depth", 32'(want.depth), 32'(got.depth));
      check_field("container_flag", 32'(want.cont), 32'(got.cont));
      check_field("blip_format", 32'(want.fmt), 32'(got.fmt));
      check_field("prefix_bytes", 32'(want.prefix), 32'(got.prefix));
      check_field("payload_pos", want.ppos, got.ppos);
      check_field("payload_len", want.plen, got.plen);
      check_field("metafile_header", 32'(want.meta), 32'(got.meta));
      check_field("compression_byte_pos", want.cpos, got.cpos);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  record_walk_scoreboard sb = new();

  logic [31:0] gen_pos  = '0;
  logic [31:0] gen_slen = '0;
  bit          calm       = 1'b0;
  bit          steady     = 1'b0;
  bit          hold_armed = 1'b0;
  int          stalled_cycles = 0;

  drawing_record_walker_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off, none at the end
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_header(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        stalled_cycles <= 0;
      else
        stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("tb_drawing_record_walker_top: done, errors");
        $finish;
      end
    end
  end

  function automatic rec_hdr_t make_hdr(input logic [3:0] ver, input logic [11:0] inst,
                                        input logic [15:0] rtype, input logic [31:0] len);
    rec_hdr_t h;
    h.ver   = ver;
    h.inst  = inst;
    h.rtype = rtype;
    h.len   = len;
    return h;
  endfunction

  // well-formed header that fits in the remaining stream
  function automatic rec_hdr_t random_header();
    rec_hdr_t    h;
    int unsigned k;
    logic [11:0] base;
    logic [31:0] room;
    room   = gen_slen - gen_pos - 32'd8;
    h.ver  = ($urandom_range(0, 9) < 3) ? CONTAINER_VER : 4'($urandom_range(0, 14));
    h.inst = 12'($urandom());
    k = $urandom_range(0, 9);
    if (k < 5) begin
      k       = $urandom_range(0, 6);
      h.rtype = IMG_TYPES[k];
      base    = (IMG_TYPES[k] == TYPE_JPEG && $urandom_range(0, 1) == 1) ? INST_JPEG2
                                                                          : IMG_INSTS[k];
      if ($urandom_range(0, 9) < 7) h.inst = base + 12'($urandom_range(0, 1));
    end else if (k < 7) begin
      h.rtype = 16'($urandom_range(TYPE_IMG_HI, TYPE_IMG_LO));
    end else begin
      h.rtype = TYPE_PREFIX_MASK | 16'($urandom_range(0, 16'h0FFF));
    end
    if (h.ver == CONTAINER_VER)
      h.len = ($urandom_range(0, 19) < 17) ? $urandom_range(0, 300) : $urandom_range(0, 3000);
    else
      h.len = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 120) : $urandom_range(0, 4000);
    if (h.len > room) h.len = room;
    return h;
  endfunction

  task automatic offer_header(input rec_hdr_t h);
    if (!calm && !steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tdata  <= h;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    gen_pos = gen_pos + 32'd8 + ((h.ver == CONTAINER_VER) ? 32'd0 : h.len);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_register(addr, value);
    if (addr == ADDR_STREAM_LEN) gen_slen = value;
  endtask

  initial begin
    rec_hdr_t    h;
    stop_kind_t  stop;
    logic [31:0] gap;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(ADDR_STREAM_LEN, 32'hFFFF_FFFF);

    // directed: empty container, field extremes, every image format and prefix
    offer_header(make_hdr(CONTAINER_VER, 12'h000, TYPE_PREFIX_MASK, 32'd0));
    offer_header(make_hdr(4'h0, 12'hFFF, 16'hFFFF, 32'd0));
    offer_header(make_hdr(CONTAINER_VER, 12'hFFF, TYPE_PREFIX_MASK, 32'd600));
    offer_header(make_hdr(CONTAINER_VER, INST_PNG, TYPE_PNG, 32'd120));
    offer_header(make_hdr(4'h2, INST_EMF, TYPE_EMF, 32'd10));
    offer_header(make_hdr(4'h2, INST_EMF + 12'd1, TYPE_EMF, 32'd66));
    offer_header(make_hdr(4'h3, INST_WMF, TYPE_WMF, 32'd50));
    offer_header(make_hdr(4'h3, INST_WMF + 12'd1, TYPE_WMF, 32'd200));
    offer_header(make_hdr(4'h1, INST_PICT, TYPE_PICT, 32'd0));
    offer_header(make_hdr(4'h1, INST_PICT + 12'd1, TYPE_PICT, 32'd70));
    offer_header(make_hdr(4'h0, INST_JPEG, TYPE_JPEG, 32'd17));
    offer_header(make_hdr(4'h0, INST_JPEG + 12'd1, TYPE_JPEG, 32'd40));
    offer_header(make_hdr(4'h0, INST_JPEG2, TYPE_JPEG, 32'd5));
    offer_header(make_hdr(4'h0, INST_JPEG2 + 12'd1, TYPE_JPEG, 32'd100));
    offer_header(make_hdr(4'h0, INST_PNG, TYPE_PNG, 32'd18));
    offer_header(make_hdr(4'h0, INST_PNG + 12'd1, TYPE_PNG, 32'd33));
    offer_header(make_hdr(4'h0, INST_DIB, TYPE_DIB, 32'd30));
    offer_header(make_hdr(4'h0, INST_DIB + 12'd1, TYPE_DIB, 32'd34));
    offer_header(make_hdr(4'h0, INST_TIFF, TYPE_TIFF, 32'd16));
    offer_header(make_hdr(4'h0, INST_TIFF + 12'd1, TYPE_TIFF, 32'd90));
    offer_header(make_hdr(4'h0, 12'h000, TYPE_EMF, 32'd60));
    offer_header(make_hdr(4'h0, INST_EMF, TYPE_IMG_LO, 32'd20));
    offer_header(make_hdr(4'h0, 12'h000, TYPE_IMG_HI, 32'd20));
    offer_header(make_hdr(4'h0, 12'h000, TYPE_IMG_HI + 16'd1, 32'd20));

    for (int chunk = 0; chunk < 4; chunk++) begin
      drain_results();
      if (chunk == 2)
        cfg_write(ADDR_STREAM_LEN, 32'hFFFF_FFFF);
      else
        cfg_write(ADDR_STREAM_LEN, $urandom_range(32'hFFFF_FFFF, gen_pos + 32'h0400_0000));
      if (chunk == 1) hold_armed = 1'b1;
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
        offer_header(random_header());
      end
    end

    // deep nesting with long containers: fills the stack past its depth
    drain_results();
    cfg_write(ADDR_STREAM_LEN, 32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) begin
      h     = random_header();
      h.ver = CONTAINER_VER;
      h.len = $urandom();
      if (h.len > gen_slen - gen_pos - 32'd8)
        h.len = $urandom_range(gen_slen - gen_pos - 32'd8, 0);
      offer_header(h);
    end
    for (int i = 0; i < 40; i++) offer_header(random_header());

    // the walk stops once, then everything after is reported as halted
    calm = 1'b1;
    drain_results();
    stop = stop_kind_t'($urandom_range(0, 4));
    gap  = $urandom_range(0, 200);
    case (stop)
      STOP_SHORT_STREAM: cfg_write(ADDR_STREAM_LEN, $urandom_range(0, 7));
      STOP_EXACT_FIT: begin
        cfg_write(ADDR_STREAM_LEN, gen_pos + 32'd8 + gap);
        drain_results();
        offer_header(make_hdr(4'h0, 12'($urandom()), TYPE_PREFIX_MASK, gap));
      end
      STOP_MARKER:
        offer_header(make_hdr(4'($urandom()), 12'($urandom()),
                              16'($urandom_range(0, 16'hEFFF)), 32'd8));
      STOP_OVERRUN_BY_ONE: begin
        cfg_write(ADDR_STREAM_LEN, gen_pos + 32'd8 + gap);
        drain_results();
        offer_header(make_hdr(4'($urandom()), 12'($urandom()), TYPE_PREFIX_MASK, gap + 32'd1));
      end
      default:
        offer_header(make_hdr(4'h0, 12'($urandom()), TYPE_PREFIX_MASK, 32'hFFFF_FFFF));
    endcase
    for (int i = 0; i < 12; i++)
      offer_header(make_hdr(4'($urandom()), 12'($urandom()), 16'($urandom()), $urandom()));
    drain_results();
    cfg_write(ADDR_STREAM_LEN, 32'd0);
    for (int i = 0; i < 6; i++) offer_header(random_header());
    drain_results();
    cfg_write(ADDR_STREAM_LEN, 32'hFFFF_FFFF);
    cfg_write(ADDR_UNMAPPED, $urandom());
    for (int i = 0; i < 6; i++) offer_header(random_header());

    drain_results();
    if (sb.errors == 0 && sb.expected_results.size() == 0)
      $display("tb_drawing_record_walker_top: done, clean");
    else
      $display("tb_drawing_record_walker_top: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/dwr_pkg.sv
rtl/dwr_queue.sv
rtl/dwr_front.sv
rtl/dwr_back.sv
rtl/drawing_record_walker_top.sv
rtl/dwr_checker.sv
test/tb_drawing_record_walker_top.sv
